// ===== rtl/core/hac_pkg.sv =====
// Shared types and constants of the heap allocation checker.
`default_nettype none
package hac_pkg;
   localparam logic [1:0] FUNC_FREE    = 2'd0;
   localparam logic [1:0] FUNC_MALLOC  = 2'd1;
   localparam logic [1:0] FUNC_CALLOC  = 2'd2;
   localparam logic [1:0] FUNC_REALLOC = 2'd3;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 24;
   localparam int SIZE_W  = 24;
   localparam int BYTES_W = 48;

   // Datapath commands issued by the controller.
   typedef struct packed {
      logic load;      // capture the input transfer
      logic rd_old;    // read bucket of the old address
      logic rd_new;    // read bucket of the new address
      logic do_rel;    // evaluate and write back a release
      logic do_claim;  // evaluate and write back a claim
      logic clr;       // clearing pass step
   } cmd_type;

   // Status returned to the controller.
   typedef struct packed {
      logic [1:0] func;
      logic       old_nz;
      logic       new_nz;
      logic       clr_done;
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/core/hac_datapath.sv =====
// Descriptor table, bucket read-modify-write logic and result register.
`default_nettype none
module hac_datapath #(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hac_pkg::cmd_type         cmd,
   output hac_pkg::sts_type              sts,
   input  wire logic [1:0]               req_func,
   input  wire logic [31:0]              req_old_addr,
   input  wire logic [31:0]              req_new_addr,
   input  wire logic [23:0]              req_obj_count,
   input  wire logic [23:0]              req_obj_size,
   output logic                          rsp_err_unallocated,
   output logic                          rsp_err_already_free,
   output logic                          rsp_err_zero_length,
   output logic                          rsp_err_already_busy,
   output logic                          rsp_err_table_full,
   output logic [47:0]                   rsp_prior_bytes
);
   import hac_pkg::*;
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef struct packed {
      logic              valid;
      logic              busy;
      logic [ADDR_W-1:0] addr;
      logic [COUNT_W-1:0] count;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // One row per bucket holds all ways.
   entry_type mem [BUCKETS][WAYS];
   entry_type row_ff [WAYS];
   logic [BW-1:0] clr_ff;
   logic [BW-1:0] bkt_ff;

   logic [1:0]         func_ff;
   logic [ADDR_W-1:0]  old_ff, new_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [SIZE_W-1:0]  size_ff;

   logic e_un_ff, e_af_ff, e_zl_ff, e_ab_ff, e_tf_ff;
   logic [COUNT_W-1:0] pc_ff;
   logic [SIZE_W-1:0]  ps_ff;

   function automatic logic [BW-1:0] bkt_of(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] s;
      s = a >> 3;
      if (BUCKETS == 1) return '0;
      return BW'(s % BUCKETS);
   endfunction

   // Hit search and first free way over the read row.
   logic [ADDR_W-1:0] key;
   logic              hit, freefound;
   logic [WW-1:0]     hw, fw;
   always_comb begin
      key = cmd.do_rel ? old_ff : new_ff;
      hit = 1'b0; freefound = 1'b0; hw = '0; fw = '0;
      for (int w = WAYS-1; w >= 0; w--) begin
         if (row_ff[w].valid && row_ff[w].addr == key) begin
            hit = 1'b1; hw = WW'(w);
         end
         if (!row_ff[w].valid) begin
            freefound = 1'b1; fw = WW'(w);
         end
      end
   end

   entry_type upd [WAYS];
   logic      wr_en;
   always_comb begin
      for (int w = 0; w < WAYS; w++) upd[w] = row_ff[w];
      wr_en = 1'b0;
      if (cmd.do_rel && hit && row_ff[hw].busy) begin
         upd[hw].busy = 1'b0; wr_en = 1'b1;
      end
      if (cmd.do_claim) begin
         if (hit) begin
            if (!(func_ff == FUNC_REALLOC && row_ff[hw].busy)) begin
               upd[hw].busy  = 1'b1;
               upd[hw].count = (func_ff == FUNC_CALLOC) ? cnt_ff : COUNT_W'(1);
               upd[hw].size  = size_ff;
               wr_en = 1'b1;
            end
         end else if (freefound) begin
            upd[fw].valid = 1'b1;
            upd[fw].busy  = 1'b1;
            upd[fw].addr  = new_ff;
            upd[fw].count = (func_ff == FUNC_CALLOC) ? cnt_ff : COUNT_W'(1);
            upd[fw].size  = size_ff;
            wr_en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         for (int w = 0; w < WAYS; w++) mem[clr_ff][w].valid <= 1'b0;
      end else if (wr_en) begin
         for (int w = 0; w < WAYS; w++) mem[bkt_ff][w] <= upd[w];
      end
      if (cmd.rd_old || cmd.rd_new) begin
         for (int w = 0; w < WAYS; w++)
            row_ff[w] <= mem[cmd.rd_old ? bkt_of(old_ff) : bkt_of(new_ff)][w];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr) clr_ff <= clr_ff + BW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_old) bkt_ff <= bkt_of(old_ff);
      if (cmd.rd_new) bkt_ff <= bkt_of(new_ff);
      if (cmd.load) begin
         func_ff <= req_func; old_ff <= req_old_addr; new_ff <= req_new_addr;
         cnt_ff <= req_obj_count; size_ff <= req_obj_size;
         e_un_ff <= 1'b0; e_af_ff <= 1'b0; e_ab_ff <= 1'b0; e_tf_ff <= 1'b0;
         pc_ff <= '0; ps_ff <= '0;
         unique case (req_func)
            FUNC_MALLOC:  e_zl_ff <= (req_obj_size == '0);
            FUNC_CALLOC:  e_zl_ff <= (req_obj_size == '0) || (req_obj_count == '0);
            FUNC_REALLOC: e_zl_ff <= (req_obj_size == '0) && (req_old_addr == '0);
            default:      e_zl_ff <= 1'b0;
         endcase
      end
      if (cmd.do_rel) begin
         if (!hit) e_un_ff <= 1'b1;
         else if (!row_ff[hw].busy) begin
            e_af_ff <= 1'b1; pc_ff <= row_ff[hw].count; ps_ff <= row_ff[hw].size;
         end
      end
      if (cmd.do_claim) begin
         if (hit && row_ff[hw].busy) e_ab_ff <= 1'b1;
         if (!hit && !freefound) e_tf_ff <= 1'b1;
      end
   end

   assign sts.func     = func_ff;
   assign sts.old_nz   = (old_ff != '0);
   assign sts.new_nz   = (new_ff != '0);
   assign sts.clr_done = (clr_ff == BW'(BUCKETS-1));

   assign rsp_err_unallocated  = e_un_ff;
   assign rsp_err_already_free = e_af_ff;
   assign rsp_err_zero_length  = e_zl_ff;
   assign rsp_err_already_busy = e_ab_ff;
   assign rsp_err_table_full   = e_tf_ff;
   assign rsp_prior_bytes      = BYTES_W'(pc_ff) * BYTES_W'(ps_ff);
endmodule
`default_nettype wire

// ===== rtl/core/hac_ctrl.sv =====
// Sequencing controller of the heap allocation checker.
`default_nettype none
module hac_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hac_pkg::cmd_type      cmd,
   input  wire hac_pkg::sts_type sts
);
   import hac_pkg::*;
   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_ROLD  = 3'd2;
   localparam logic [2:0] S_REL   = 3'd3;
   localparam logic [2:0] S_RNEW  = 3'd4;
   localparam logic [2:0] S_CLAIM = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       take;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign take      = req_valid && !req_stall;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: if (take) begin
            cmd.load = 1'b1; state_in = S_ROLD;
         end
         S_ROLD: begin
            if ((sts.func == FUNC_FREE || sts.func == FUNC_REALLOC) && sts.old_nz) begin
               cmd.rd_old = 1'b1; state_in = S_REL;
            end else state_in = S_RNEW;
         end
         S_REL: begin
            cmd.do_rel = 1'b1;
            state_in = (sts.func == FUNC_FREE) ? S_OUT : S_RNEW;
         end
         S_RNEW: begin
            if (sts.func != FUNC_FREE && sts.new_nz) begin
               cmd.rd_new = 1'b1; state_in = S_CLAIM;
            end else state_in = S_OUT;
         end
         S_CLAIM: begin
            cmd.do_claim = 1'b1; state_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLR;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/heap_allocation_checker_core.sv =====
// Top level of the heap allocation checker.
// Usage: each transfer on the req_ channel is one allocation event (free,
// malloc, calloc or realloc). The block looks up a set-associative table of
// descriptors in BUCKETS buckets of WAYS entries, updates it, and returns one
// transfer on the rsp_ channel with the error flags and, for a double free,
// the byte length of the block.
// An event runs through S_ROLD and S_REL, a bucket read and write-back of
// the old address (free, realloc), S_RNEW and S_CLAIM, the same for the new
// address (malloc, calloc, realloc), each in the single-port bucket memory
// and skipped for a null address, then S_OUT with the result. Only one event
// is in flight at a time; the next event is taken the cycle after the result
// transfer. After reset the block sweeps the table and clears every valid
// bit, one bucket per cycle, holding req_stall high meanwhile.
// When the receiver stalls, the result stays on the rsp_ ports unchanged and
// req_stall remains high until the result transfer completes.
`default_nettype none
module heap_allocation_checker_core #(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_old_addr,
   input  wire logic [31:0] req_new_addr,
   input  wire logic [23:0] req_obj_count,
   input  wire logic [23:0] req_obj_size,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_err_unallocated,
   output logic             rsp_err_already_free,
   output logic             rsp_err_zero_length,
   output logic             rsp_err_already_busy,
   output logic             rsp_err_table_full,
   output logic [47:0]      rsp_prior_bytes
);
   import hac_pkg::*;
   cmd_type cmd;
   sts_type sts;

   // The controller sequences each event through the table datapath.
   hac_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   hac_datapath #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_func, .req_old_addr, .req_new_addr, .req_obj_count, .req_obj_size,
      .rsp_err_unallocated, .rsp_err_already_free, .rsp_err_zero_length,
      .rsp_err_already_busy, .rsp_err_table_full, .rsp_prior_bytes
   );

   // A double free and a missing descriptor exclude each other.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_err_unallocated && rsp_err_already_free))
      else $error("unallocated and already free together");
   // A length is reported only for a double free.
   a_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_err_already_free) |-> (rsp_prior_bytes == '0))
      else $error("prior bytes without double free");
   // The input is never taken while a result waits.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open with pending result");
endmodule
`default_nettype wire

// ===== tb/heap_allocation_checker_checker.sv =====
// Checker that predicts and compares the results of the heap allocation checker.
`default_nettype none
module heap_allocation_checker_checker #(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_old_addr,
   input  wire logic [31:0] req_new_addr,
   input  wire logic [23:0] req_obj_count,
   input  wire logic [23:0] req_obj_size,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_err_unallocated,
   input  wire logic        rsp_err_already_free,
   input  wire logic        rsp_err_zero_length,
   input  wire logic        rsp_err_already_busy,
   input  wire logic        rsp_err_table_full,
   input  wire logic [47:0] rsp_prior_bytes,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import hac_pkg::*;

   localparam int ENTRIES = BUCKETS * WAYS;

   typedef struct packed {
      logic               unallocated;
      logic               already_free;
      logic               zero_length;
      logic               already_busy;
      logic               table_full;
      logic [BYTES_W-1:0] prior_bytes;
   } flags_type;

   // Shadow copy of the descriptor table.
   logic               desc_valid [ENTRIES];
   logic [ADDR_W-1:0]  desc_addr  [ENTRIES];
   logic               desc_busy  [ENTRIES];
   logic [COUNT_W-1:0] desc_count [ENTRIES];
   logic [SIZE_W-1:0]  desc_size  [ENTRIES];

   flags_type expected_flags[$];

   function automatic int find_desc(logic [ADDR_W-1:0] addr);
      int base;
      base = ((addr >> 3) % BUCKETS) * WAYS;
      for (int w = 0; w < WAYS; w++)
         if (desc_valid[base + w] && desc_addr[base + w] == addr) return base + w;
      return -1;
   endfunction

   function automatic bit add_desc(logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] cnt,
                                   logic [SIZE_W-1:0] sz);
      int base;
      base = ((addr >> 3) % BUCKETS) * WAYS;
      for (int w = 0; w < WAYS; w++) begin
         if (!desc_valid[base + w]) begin
            desc_valid[base + w] = 1'b1;
            desc_addr[base + w]  = addr;
            desc_busy[base + w]  = 1'b1;
            desc_count[base + w] = cnt;
            desc_size[base + w]  = sz;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void release_block(logic [ADDR_W-1:0] addr, ref flags_type f);
      int i;
      if (addr == '0) return;
      i = find_desc(addr);
      if (i < 0) f.unallocated = 1'b1;
      else if (!desc_busy[i]) begin
         f.already_free = 1'b1;
         f.prior_bytes  = BYTES_W'(desc_count[i]) * BYTES_W'(desc_size[i]);
      end else desc_busy[i] = 1'b0;
   endfunction

   // Malloc and calloc always overwrite an existing descriptor.
   function automatic void claim_block(logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] cnt,
                                       logic [SIZE_W-1:0] sz, ref flags_type f);
      int i;
      if (addr == '0) return;
      i = find_desc(addr);
      if (i >= 0) begin
         if (desc_busy[i]) f.already_busy = 1'b1;
         desc_count[i] = cnt;
         desc_size[i]  = sz;
         desc_busy[i]  = 1'b1;
      end else if (!add_desc(addr, cnt, sz)) f.table_full = 1'b1;
   endfunction

   function automatic flags_type track_event(logic [1:0] fn, logic [ADDR_W-1:0] old_a,
                                             logic [ADDR_W-1:0] new_a,
                                             logic [COUNT_W-1:0] cnt, logic [SIZE_W-1:0] sz);
      flags_type f;
      int j;
      f = '0;
      case (fn)
         FUNC_FREE: release_block(old_a, f);
         FUNC_MALLOC: begin
            if (sz == '0) f.zero_length = 1'b1;
            claim_block(new_a, COUNT_W'(1), sz, f);
         end
         FUNC_CALLOC: begin
            if (cnt == '0 || sz == '0) f.zero_length = 1'b1;
            claim_block(new_a, cnt, sz, f);
         end
         default: begin
            // Realloc never overwrites a busy destination.
            if (old_a == '0 && sz == '0) f.zero_length = 1'b1;
            release_block(old_a, f);
            if (new_a != '0) begin
               j = find_desc(new_a);
               if (j >= 0 && desc_busy[j]) f.already_busy = 1'b1;
               else if (j >= 0) begin
                  desc_count[j] = COUNT_W'(1);
                  desc_size[j]  = sz;
                  desc_busy[j]  = 1'b1;
               end else if (!add_desc(new_a, COUNT_W'(1), sz)) f.table_full = 1'b1;
            end
         end
      endcase
      return f;
   endfunction

   always @(posedge clock) begin
      flags_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) desc_valid[i] = 1'b0;
         expected_flags.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_flags.push_back(track_event(req_func, req_old_addr, req_new_addr,
                                                 req_obj_count, req_obj_size));
         if (rsp_valid && !rsp_stall) begin
            if (expected_flags.size() == 0) begin
               $error("result transfer with no event outstanding");
               fail_count++;
            end else begin
               want = expected_flags.pop_front();
               if (rsp_err_unallocated !== want.unallocated) begin
                  $error("err_unallocated: expected %0d, got %0d",
                         want.unallocated, rsp_err_unallocated);
                  fail_count++;
               end
               if (rsp_err_already_free !== want.already_free) begin
                  $error("err_already_free: expected %0d, got %0d",
                         want.already_free, rsp_err_already_free);
                  fail_count++;
               end
               if (rsp_err_zero_length !== want.zero_length) begin
                  $error("err_zero_length: expected %0d, got %0d",
                         want.zero_length, rsp_err_zero_length);
                  fail_count++;
               end
               if (rsp_err_already_busy !== want.already_busy) begin
                  $error("err_already_busy: expected %0d, got %0d",
                         want.already_busy, rsp_err_already_busy);
                  fail_count++;
               end
               if (rsp_err_table_full !== want.table_full) begin
                  $error("err_table_full: expected %0d, got %0d",
                         want.table_full, rsp_err_table_full);
                  fail_count++;
               end
               if (rsp_prior_bytes !== want.prior_bytes) begin
                  $error("prior_bytes: expected %0h, got %0h",
                         want.prior_bytes, rsp_prior_bytes);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_flags.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end
endmodule
`default_nettype wire

// ===== tb/heap_allocation_checker_core_tb.sv =====
// Testbench top: stimulus, result back-pressure, watchdog and verdict.
`default_nettype none
module heap_allocation_checker_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hac_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;  // covers the clearing sweep and the long hold-off
   localparam int HOLD_CYCLES    = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_FREE;
   logic [31:0] req_old_addr = '0;
   logic [31:0] req_new_addr = '0;
   logic [23:0] req_obj_count = '0;
   logic [23:0] req_obj_size = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_err_unallocated, rsp_err_already_free, rsp_err_zero_length;
   logic        rsp_err_already_busy, rsp_err_table_full;
   logic [47:0] rsp_prior_bytes;
   int          fail_count, pending;

   // The clock runs with a 2 ns period: one delay for each phase.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   heap_allocation_checker_core u_top (.*);

   heap_allocation_checker_checker u_checker (.*);

   // Half of the gaps are empty and most others short; now and then one runs much longer.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Addresses mostly land in a handful of buckets so that ways fill up and
   // blocks are freed and reclaimed often; the rest are null, all ones or random.
   function automatic logic [31:0] pick_addr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 75)
         return 32'($urandom_range(0, 5)) * 32'd2048 + 32'($urandom_range(0, 3)) * 32'd8
                + 32'd8;
      if (r < 80) return '1;
      return $urandom;
   endfunction

   function automatic logic [23:0] pick_amount();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 18) return '1;
      if (r < 70) return 24'($urandom_range(1, 64));
      return 24'($urandom);
   endfunction

   // Presents one event after a random idle gap and holds it until the block
   // takes the transfer. The payload changes only at the falling edge.
   task automatic offer_event(logic [1:0] fn, logic [31:0] old_a, logic [31:0] new_a,
                              logic [23:0] cnt, logic [23:0] sz);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func      = fn;
      req_old_addr  = old_a;
      req_new_addr  = new_a;
      req_obj_count = cnt;
      req_obj_size  = sz;
      req_valid     = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stimulus: a directed pass over the special cases, then random traffic.
   initial begin
      logic [1:0] fn;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      offer_event(FUNC_FREE,    32'h0,        32'h0,        24'd0,   24'd0);    // null free
      offer_event(FUNC_FREE,    32'h0000_1000, 32'h0,       24'd0,   24'd0);    // unknown block
      offer_event(FUNC_MALLOC,  32'h0,        32'h0000_2000, 24'd9,  24'd0);    // zero length
      offer_event(FUNC_CALLOC,  32'h0,        32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF);
      offer_event(FUNC_FREE,    32'hFFFF_FFFF, 32'h0,       24'd0,   24'd0);
      offer_event(FUNC_FREE,    32'hFFFF_FFFF, 32'h0,       24'd0,   24'd0);    // double free
      offer_event(FUNC_CALLOC,  32'h0,        32'h0000_3000, 24'd0,  24'd5);    // zero count
      offer_event(FUNC_MALLOC,  32'h0,        32'h0000_3000, 24'd3,  24'd7);    // still busy
      offer_event(FUNC_MALLOC,  32'h0,        32'h0,        24'd0,   24'd4);    // null result
      offer_event(FUNC_REALLOC, 32'h0,        32'h0,        24'd0,   24'd0);    // null to zero
      offer_event(FUNC_REALLOC, 32'h0000_3000, 32'h0000_3000, 24'd0, 24'd12);   // same address
      offer_event(FUNC_REALLOC, 32'h0000_2000, 32'h0000_3000, 24'd0, 24'd3);    // onto busy block
      offer_event(FUNC_REALLOC, 32'h0000_4000, 32'hFFFF_FFFF, 24'd0, 24'd6);    // reclaim freed
      // Five blocks in one bucket: the last one does not fit.
      for (int k = 1; k <= 5; k++)
         offer_event(FUNC_MALLOC, 32'h0, 32'(k) * 32'h800 + 32'h10, 24'd0, 24'd16);
      offer_event(FUNC_FREE,    32'h0000_2810, 32'h0,       24'd0,   24'd0);    // never stored
      offer_event(FUNC_REALLOC, 32'h0000_0810, 32'h0000_3010, 24'd0, 24'd1);   // bucket full
      offer_event(FUNC_FREE,    32'h0000_0810, 32'h0,       24'd0,   24'd0);    // double free
      offer_event(FUNC_REALLOC, 32'h0000_0810, 32'h0000_0810, 24'd0, 24'd0);    // double free, then reclaim

      for (int n = 0; n < 880; n++) begin
         fn = 2'($urandom_range(0, 3));
         offer_event(fn, pick_addr(), pick_addr(), pick_amount(), pick_amount());
      end
      req_valid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Result back-pressure. Early on the receiver holds off long enough for
   // the block to fill up and stall its input while events keep coming.
   initial begin
      int mode;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (700) @(negedge clock);
      rsp_stall = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 9);
         if (mode < 3) begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end else if (mode < 9) begin
            repeat ($urandom_range(10, 40)) begin
               rsp_stall = ($urandom_range(0, 3) == 0);
               @(negedge clock);
            end
         end else begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a transfer.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/hac_pkg.sv
rtl/core/hac_datapath.sv
rtl/core/hac_ctrl.sv
rtl/core/heap_allocation_checker_core.sv
tb/heap_allocation_checker_checker.sv
tb/heap_allocation_checker_core_tb.sv
